// File: src/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons)
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/rau_pkg.sv
// Package: types and constants of the rational arithmetic unit.
`default_nettype none
package rau_pkg;
   localparam int OPERAND_BITS_DEF = 16;
   localparam int NUM_W = 33;
   localparam int DEN_W = 31;
   localparam int MAG_W = 64;
   localparam int CNT_W = 7;

   typedef enum logic [2:0] {
      KIND_ADD = 3'd0, KIND_SUB = 3'd1, KIND_MUL = 3'd2,
      KIND_DIV = 3'd3, KIND_CMP = 3'd4, KIND_FLOOR = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_GCD, ST_DIV, ST_DONE
   } state_type;

   // classified work item handed from front to back
   typedef struct packed {
      logic [2:0] kind;
      logic       err;
      logic       a_neg;
      logic [31:0] a_mag;
      logic       c_neg;
      logic [31:0] c_mag;
      logic       b_neg;
      logic [31:0] b_mag;
      logic       d_neg;
      logic [31:0] d_mag;
   } work_type;
endpackage
`default_nettype wire

// File: src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Exact fraction arithmetic: add, subtract, multiply, divide, compare and floor on
// two operands A = a_num/a_den and B = b_num/b_den. A front stage takes a request,
// splits the operands into sign and magnitude and flags zero denominators, unused
// kinds and division by zero; a two-entry queue feeds the back end. The back end
// forms cross products in its MUL state, reduces by a binary GCD (one halving or one
// subtract per cycle, data dependent), then divides numerator and denominator by the
// GCD with a one-bit-per-cycle restoring divider. Compare and errors skip the GCD and
// the divider; floor skips the GCD. One request is worked at a time in the back end
// while the next waits in the queue. Errors give res_num 0, res_den 0, cmp_sign 0 and
// error 1.
`default_nettype none
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // tdata: a_num, a_den, b_num, b_den from bit 0 up
   input  wire logic [4*OPERAND_BITS-1:0] req_tdata,
   // tuser: kind
   input  wire logic [2:0]              req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // tdata: res_num, res_den, cmp_sign, error from bit 0 up, zero fill to 72 bits
   output logic [71:0]                  rsp_tdata
);
   logic       q_valid, q_ready;
   work_type   q_data;
   logic [NUM_W-1:0] res_num;
   logic [DEN_W-1:0] res_den;
   logic [1:0] cmp_sign;
   logic       error;

   rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .kind(req_tuser),
      .a_num(req_tdata[OPERAND_BITS-1:0]),
      .a_den(req_tdata[2*OPERAND_BITS-1:OPERAND_BITS]),
      .b_num(req_tdata[3*OPERAND_BITS-1:2*OPERAND_BITS]),
      .b_den(req_tdata[4*OPERAND_BITS-1:3*OPERAND_BITS]),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   rau_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .res_num(res_num), .res_den(res_den), .cmp_sign(cmp_sign), .error(error)
   );

   assign rsp_tdata = {5'd0, error, cmp_sign, res_den, res_num};
endmodule
`default_nettype wire

// File: src/rau_front.sv
// Front end: accepts requests, splits operands into sign and magnitude, flags errors.
`default_nettype none
module rau_front
   import rau_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [2:0]                kind,
   input  wire logic [OPERAND_BITS-1:0]   a_num,
   input  wire logic [OPERAND_BITS-1:0]   a_den,
   input  wire logic [OPERAND_BITS-1:0]   b_num,
   input  wire logic [OPERAND_BITS-1:0]   b_den,
   output logic                           q_valid,
   input  wire logic                      q_ready,
   output work_type                       q_data
);
   localparam int DEPTH = 2;
   work_type      mem_ff [DEPTH];
   logic [1:0]    cnt_ff, cnt_in;
   logic          wp_ff, rp_ff;
   work_type      w;
   logic          push, pop;

   function automatic logic [31:0] mag(input logic [OPERAND_BITS-1:0] v);
      logic [OPERAND_BITS-1:0] t;
      t = v[OPERAND_BITS-1] ? (~v + 1'b1) : v;
      return 32'(t);
   endfunction

   always_comb begin
      w.kind  = kind;
      w.a_neg = a_num[OPERAND_BITS-1];
      w.a_mag = mag(a_num);
      w.c_neg = a_den[OPERAND_BITS-1];
      w.c_mag = mag(a_den);
      w.b_neg = b_num[OPERAND_BITS-1];
      w.b_mag = mag(b_num);
      w.d_neg = b_den[OPERAND_BITS-1];
      w.d_mag = mag(b_den);
      w.err   = (kind > 3'(KIND_FLOOR)) || (w.c_mag == '0) ||
                ((kind != 3'(KIND_FLOOR)) && (w.d_mag == '0)) ||
                ((kind == 3'(KIND_DIV)) && (w.b_mag == '0));
   end

   assign in_ready = (cnt_ff != 2'(DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign q_data   = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= w;
   end
endmodule
`default_nettype wire

// File: src/rau_back.sv
// Back end: cross products, binary GCD and restoring divides for reduction.
`default_nettype none
module rau_back
   import rau_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_ready,
   input  wire work_type          q_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [NUM_W-1:0]       res_num,
   output logic [DEN_W-1:0]       res_den,
   output logic [1:0]             cmp_sign,
   output logic                   error
);
`include "rational_arithmetic_unit_assert.svh"
   state_type state_ff, state_in;
   work_type  w_ff;
   logic [MAG_W-1:0] p0_ff, p1_ff, p2_ff;   // a*d (or a*b), b*c, c*d (or c*b)
   logic             s0_ff, s1_ff, s2_ff;
   logic [MAG_W-1:0] n_ff, x_ff, y_ff;
   logic [CNT_W-1:0] sh_ff;              // common factors of two pulled out of the GCD
   logic             nneg_ff;
   logic [MAG_W-1:0] quo_ff, rem_ff, dvs_ff, dvd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             dsel_ff;            // 0: dividing numerator, 1: denominator
   logic [MAG_W-1:0] nq_ff;
   logic [NUM_W-1:0] onum_ff;
   logic [DEN_W-1:0] oden_ff;
   logic [1:0]       ocmp_ff;
   logic             oerr_ff;
   logic [MAG_W-1:0] rsh, g;
   logic             take;

   assign q_ready   = (state_ff == ST_IDLE);
   assign take      = q_valid && q_ready;
   assign out_valid = (state_ff == ST_DONE);
   assign res_num   = onum_ff;
   assign res_den   = oden_ff;
   assign cmp_sign  = ocmp_ff;
   assign error     = oerr_ff;
   assign rsh       = {rem_ff[MAG_W-2:0], dvd_ff[MAG_W-1]};
   assign g         = (x_ff | y_ff) << sh_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (take) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM: begin
            if (w_ff.err || w_ff.kind == 3'(KIND_CMP)) state_in = ST_DONE;
            else if (w_ff.kind == 3'(KIND_FLOOR)) state_in = ST_DIV;
            else state_in = ST_GCD;
         end
         ST_GCD: if (x_ff == '0 || y_ff == '0) state_in = ST_DIV;
         ST_DIV: if (cnt_ff == '0 && (dsel_ff || w_ff.kind == 3'(KIND_FLOOR)))
            state_in = ST_DONE;
         ST_DONE: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      logic [MAG_W-1:0] sum;
      logic             sneg;
      logic [MAG_W-1:0] r2;
      logic [MAG_W-1:0] qn;
      logic [MAG_W-1:0] fq;
      case (state_ff)
         ST_IDLE: if (take) w_ff <= q_data;
         ST_MUL: begin
            p0_ff <= 64'(w_ff.a_mag) *
                     64'((w_ff.kind == 3'(KIND_MUL)) ? w_ff.b_mag : w_ff.d_mag);
            s0_ff <= w_ff.a_neg ^ ((w_ff.kind == 3'(KIND_MUL)) ? w_ff.b_neg : w_ff.d_neg);
            p1_ff <= 64'(w_ff.b_mag) * 64'(w_ff.c_mag);
            s1_ff <= w_ff.b_neg ^ w_ff.c_neg ^ (w_ff.kind != 3'(KIND_ADD));
            p2_ff <= 64'(w_ff.c_mag) *
                     64'((w_ff.kind == 3'(KIND_DIV)) ? w_ff.b_mag : w_ff.d_mag);
            s2_ff <= w_ff.c_neg ^ ((w_ff.kind == 3'(KIND_DIV)) ? w_ff.b_neg : w_ff.d_neg);
         end
         ST_SUM: begin
            if (w_ff.kind == 3'(KIND_MUL) || w_ff.kind == 3'(KIND_DIV)) begin
               sum = p0_ff; sneg = s0_ff;
            end else if (s0_ff == s1_ff) begin
               sum = p0_ff + p1_ff; sneg = s0_ff;
            end else if (p0_ff >= p1_ff) begin
               sum = p0_ff - p1_ff; sneg = s0_ff;
            end else begin
               sum = p1_ff - p0_ff; sneg = s1_ff;
            end
            n_ff    <= sum;
            nneg_ff <= (sneg ^ s2_ff) && (sum != '0);
            x_ff    <= sum;
            y_ff    <= p2_ff;
            sh_ff   <= '0;
            oerr_ff <= w_ff.err;
            ocmp_ff <= 2'd0;
            onum_ff <= '0;
            oden_ff <= w_ff.err ? '0 : DEN_W'(1);
            if (w_ff.kind == 3'(KIND_CMP) && !w_ff.err)
               ocmp_ff <= (sum == '0) ? 2'd1 : ((sneg ^ s2_ff) ? 2'd0 : 2'd2);
            // floor: divide |a| by |c|
            dvd_ff  <= 64'(w_ff.a_mag);
            dvs_ff  <= 64'(w_ff.c_mag);
            rem_ff  <= '0;
            quo_ff  <= '0;
            cnt_ff  <= CNT_W'(MAG_W);
            dsel_ff <= 1'b0;
         end
         ST_GCD: begin
            // binary GCD: halve an even side or subtract the smaller odd side
            if (x_ff == '0 || y_ff == '0) begin
               dvd_ff <= n_ff;
               dvs_ff <= g;
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= CNT_W'(MAG_W);
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_ff  <= x_ff >> 1;
               y_ff  <= y_ff >> 1;
               sh_ff <= sh_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_ff <= x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_ff <= y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_ff <= x_ff - y_ff;
            end else begin
               y_ff <= y_ff - x_ff;
            end
         end
         ST_DIV: begin
            if (cnt_ff != '0) begin
               r2 = (rsh >= dvs_ff) ? rsh - dvs_ff : rsh;
               rem_ff <= r2;
               quo_ff <= {quo_ff[MAG_W-2:0], rsh >= dvs_ff};
               dvd_ff <= {dvd_ff[MAG_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
            end else if (w_ff.kind == 3'(KIND_FLOOR)) begin
               fq = quo_ff + 64'((w_ff.a_neg != w_ff.c_neg) && (rem_ff != '0));
               onum_ff <= (w_ff.a_neg != w_ff.c_neg) ? NUM_W'(~fq + 1'b1) : NUM_W'(fq);
            end else if (!dsel_ff) begin
               qn = quo_ff;
               nq_ff  <= qn;
               dsel_ff <= 1'b1;
               dvd_ff <= p2_ff;
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= CNT_W'(MAG_W);
            end else begin
               onum_ff <= nneg_ff ? NUM_W'(~nq_ff + 1'b1) : NUM_W'(nq_ff);
               oden_ff <= DEN_W'(quo_ff);
            end
         end
         default: ;
      endcase
   end

   `RAU_ASSERT_IMP(a_err_den, clock, reset, out_valid && error, res_den == '0 && cmp_sign == 2'd0)
   `RAU_ASSERT_IMP(a_ok_den, clock, reset, out_valid && !error, res_den != '0)
   `RAU_ASSERT_NXT(a_hold, clock, reset, out_valid && !out_ready, out_valid && $stable(res_num))
   `RAU_ASSERT_IMP(a_one_side, clock, reset, q_ready, !out_valid)
endmodule
`default_nettype wire

// File: tb/tb_rational_arithmetic_unit.sv
// Testbench for the rational arithmetic unit: directed and random requests, scoreboard check.
`default_nettype none
module tb_rational_arithmetic_unit
   import rau_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // one request: kind and two fractions; hold makes the sender wait for a drained unit
   typedef struct {
      logic [2:0]         kind;
      logic signed [15:0] a_num;
      logic signed [15:0] a_den;
      logic signed [15:0] b_num;
      logic signed [15:0] b_den;
      bit                 hold;
   } fraction_req_type;

   typedef struct {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [1:0]       cmp;
      logic             err;
   } fraction_rsp_type;

   localparam logic [2:0] KIND_BAD6 = 3'd6;
   localparam logic [2:0] KIND_BAD7 = 3'd7;
   localparam logic [1:0] CMP_LESS = 2'd0, CMP_EQUAL = 2'd1, CMP_GREATER = 2'd2;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;

   rational_arithmetic_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   fraction_req_type pending_reqs[$];
   fraction_rsp_type expected_results[$];
   int               error_count = 0;
   int               result_count = 0;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------------------------------------------------------- predictor
   // numerator and denominator of the unreduced fraction for add/sub/mul/div
   function automatic void fraction_terms(input fraction_req_type r, output longint n,
                                          output longint q);
      longint a, c, b, d;
      a = r.a_num;
      c = r.a_den;
      b = r.b_num;
      d = r.b_den;
      case (r.kind)
         KIND_ADD: begin
            n = a * d + b * c;
            q = c * d;
         end
         KIND_SUB: begin
            n = a * d - b * c;
            q = c * d;
         end
         KIND_MUL: begin
            n = a * b;
            q = c * d;
         end
         default: begin
            n = a * d;
            q = c * b;
         end
      endcase
   endfunction

   function automatic bit is_error_req(input fraction_req_type r);
      return r.kind > KIND_FLOOR || r.a_den == 0 || (r.kind != KIND_FLOOR && r.b_den == 0)
             || (r.kind == KIND_DIV && r.b_num == 0);
   endfunction

   function automatic longint greatest_divisor(input longint x, input longint y);
      longint t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return (x == 0) ? 1 : x;
   endfunction

   function automatic fraction_rsp_type reduce_fraction(input fraction_req_type r);
      fraction_rsp_type res;
      longint n, q, x, y, g, diff, cd;
      res = '{num: '0, den: '0, cmp: CMP_LESS, err: 1'b0};
      if (is_error_req(r)) begin
         res.err = 1'b1;
         return res;
      end
      res.den = DEN_W'(1);
      if (r.kind == KIND_FLOOR) begin
         // true floor: only inexact negative quotients step down
         x = longint'(r.a_num) / longint'(r.a_den);
         if ((longint'(r.a_num) % longint'(r.a_den)) != 0 && ((r.a_num < 0) != (r.a_den < 0)))
            x = x - 1;
         res.num = x[NUM_W-1:0];
         return res;
      end
      if (r.kind == KIND_CMP) begin
         diff = longint'(r.a_num) * r.b_den - longint'(r.b_num) * r.a_den;
         cd = longint'(r.a_den) * r.b_den;
         if (diff == 0) res.cmp = CMP_EQUAL;
         else if ((diff < 0) != (cd < 0)) res.cmp = CMP_LESS;
         else res.cmp = CMP_GREATER;
         return res;
      end
      fraction_terms(r, n, q);
      x = (n < 0) ? -n : n;
      y = (q < 0) ? -q : q;
      g = greatest_divisor(x, y);
      x = x / g;
      if ((n < 0) != (q < 0)) x = -x;
      res.num = x[NUM_W-1:0];
      res.den = DEN_W'(y / g);
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic logic signed [15:0] pick_operand();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom);
         4, 5, 6, 7: return ($urandom_range(0, 1) ? 16'sd1 : -16'sd1) *
                            $signed({8'd0, 8'($urandom_range(1, 255))});
         8: begin
            case ($urandom_range(0, 3))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         default: return 16'sd0;
      endcase
   endfunction

   function automatic fraction_req_type random_req();
      fraction_req_type r;
      r.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
      r.a_num = pick_operand();
      r.a_den = pick_operand();
      r.b_num = pick_operand();
      r.b_den = pick_operand();
      r.hold = 0;
      return r;
   endfunction

   function automatic fraction_req_type mk_req(input logic [2:0] k, input int an,
                                               input int ad, input int bn, input int bd);
      fraction_req_type r;
      r.kind = k;
      r.a_num = 16'(an);
      r.a_den = 16'(ad);
      r.b_num = 16'(bn);
      r.b_den = 16'(bd);
      r.hold = 0;
      return r;
   endfunction

   // ---------------------------------------------------------------- driver
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].hold &&
                        (req_tvalid || expected_results.size() != 0))) begin
            req_tdata <= {pending_reqs[0].b_den, pending_reqs[0].b_num,
                          pending_reqs[0].a_den, pending_reqs[0].a_num};
            req_tuser <= pending_reqs[0].kind;
            req_tvalid <= 1'b1;
            void'(pending_reqs.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               // some bursts run back to back
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver stall pattern
   int  stall_left = 0;
   int  stretch_left = 0;
   bit  stretch_busy = 0;
   bit  long_stall_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!long_stall_done && result_count >= 300) begin
         // long hold-off: the unit's queue fills and the request side stalls
         long_stall_done <= 1;
         stall_left <= 3000;
         rsp_tready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            stretch_left <= $urandom_range(20, 200);
            stretch_busy <= $urandom_range(0, 1);
         end else begin
            stretch_left <= stretch_left - 1;
         end
         rsp_tready <= stretch_busy ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor and checker
   always @(posedge clock) begin
      fraction_req_type  acc;
      fraction_rsp_type  want;
      if (!reset && req_tvalid && req_tready) begin
         acc.kind = req_tuser;
         acc.a_num = req_tdata[15:0];
         acc.a_den = req_tdata[31:16];
         acc.b_num = req_tdata[47:32];
         acc.b_den = req_tdata[63:48];
         acc.hold = 0;
         expected_results.push_back(reduce_fraction(acc));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count <= result_count + 1;
         if (expected_results.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[32:0] !== want.num) begin
               $error("res_num expected %h actual %h", want.num, rsp_tdata[32:0]);
               error_count++;
            end
            if (rsp_tdata[63:33] !== want.den) begin
               $error("res_den expected %h actual %h", want.den, rsp_tdata[63:33]);
               error_count++;
            end
            if (rsp_tdata[65:64] !== want.cmp) begin
               $error("cmp_sign expected %h actual %h", want.cmp, rsp_tdata[65:64]);
               error_count++;
            end
            if (rsp_tdata[66] !== want.err) begin
               $error("error expected %h actual %h", want.err, rsp_tdata[66]);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      fraction_req_type r;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: every kind, extremes, errors, floor and compare corners
      pending_reqs.push_back(mk_req(KIND_ADD, 1, 2, 1, 3));
      pending_reqs.push_back(mk_req(KIND_SUB, 1, 2, 1, 2));
      pending_reqs.push_back(mk_req(KIND_MUL, -3, 4, 8, -9));
      pending_reqs.push_back(mk_req(KIND_DIV, 5, -7, -10, 21));
      pending_reqs.push_back(mk_req(KIND_ADD, 32767, -32768, -32768, 32767));
      pending_reqs.push_back(mk_req(KIND_MUL, -32768, -32768, -32768, -32768));
      pending_reqs.push_back(mk_req(KIND_SUB, -32768, 32767, 32767, -32768));
      pending_reqs.push_back(mk_req(KIND_DIV, -32768, 32767, 32767, -32768));
      pending_reqs.push_back(mk_req(KIND_ADD, 0, -5, 0, 7));
      pending_reqs.push_back(mk_req(KIND_MUL, 32767, 1, 1, 32767));
      pending_reqs.push_back(mk_req(KIND_DIV, 32767, 1, 1, 32766));
      pending_reqs.push_back(mk_req(KIND_CMP, 1, 3, 2, 6));
      pending_reqs.push_back(mk_req(KIND_CMP, 1, -3, 1, 3));
      pending_reqs.push_back(mk_req(KIND_CMP, -32768, -1, 32767, 1));
      pending_reqs.push_back(mk_req(KIND_FLOOR, -6, 3, 0, 0));
      pending_reqs.push_back(mk_req(KIND_FLOOR, -7, 3, 9, 9));
      pending_reqs.push_back(mk_req(KIND_FLOOR, 7, -3, 0, 0));
      pending_reqs.push_back(mk_req(KIND_FLOOR, -32768, 1, 0, 0));
      pending_reqs.push_back(mk_req(KIND_FLOOR, 32767, -1, 0, 1));
      pending_reqs.push_back(mk_req(KIND_DIV, 3, 4, 0, 5));
      pending_reqs.push_back(mk_req(KIND_ADD, 3, 0, 1, 2));
      pending_reqs.push_back(mk_req(KIND_MUL, 3, 2, 1, 0));
      pending_reqs.push_back(mk_req(KIND_FLOOR, 3, 0, 1, 2));
      pending_reqs.push_back(mk_req(KIND_BAD6, 1, 1, 1, 1));
      pending_reqs.push_back(mk_req(KIND_BAD7, -1, -1, -1, -1));

      for (int i = 0; i < 1650; i++) begin
         r = random_req();
         // pause here until the unit has drained
         if (i == 0 || i == 900) r.hold = 1;
         pending_reqs.push_back(r);
      end

      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_tvalid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
